// ===== rtl/core/retro_video_memory_port_core_macros.svh =====
// Assertion helpers shared by the core. Each macro expects clk and arst_n
// to be visible in the module where it is used.
`ifndef RETRO_VIDEO_MEMORY_PORT_CORE_MACROS_SVH
`define RETRO_VIDEO_MEMORY_PORT_CORE_MACROS_SVH

// Same-cycle implication.
`define RVMP_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rvmp assertion failed");

// Next-cycle implication.
`define RVMP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rvmp assertion failed");

`endif

// ===== rtl/core/rvmp_pkg.sv =====
`default_nettype none

package rvmp_pkg;

	localparam int TEXT_ROWS        = 24;
	localparam int TEXT_COLS        = 40;
	localparam int CELL_COUNT       = TEXT_ROWS * TEXT_COLS;
	localparam int HIRES_PAGE_BYTES = 8192;
	localparam int TEXT_ADDR_W      = $clog2(CELL_COUNT);
	localparam int HIRES_ADDR_W     = $clog2(HIRES_PAGE_BYTES);

	localparam logic [6:0] TEXT_FILL = 7'h20;

	// Bus commands.
	localparam logic [1:0] CMD_WRITE  = 2'd0;
	localparam logic [1:0] CMD_READ   = 2'd1;
	localparam logic [1:0] CMD_SWITCH = 2'd2;

	// Soft switch low-byte codes.
	localparam logic [7:0] SW_MIXED = 8'h53;
	localparam logic [7:0] SW_PAGE1 = 8'h54;
	localparam logic [7:0] SW_PAGE2 = 8'h55;
	localparam logic [7:0] SW_HIRES = 8'h57;

	// Display modes.
	localparam logic [1:0] MODE_TEXT  = 2'd0;
	localparam logic [1:0] MODE_HIRES = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] address;
		logic [7:0]  write_data;
	} access_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [1:0] display_mode;
		logic       show_second_page;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                    accept;
		logic                    load_out;
		logic                    clear_en;
		logic [HIRES_ADDR_W-1:0] clear_addr;
	} ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/rvmp_ctrl.sv =====
`default_nettype none

module rvmp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              access_valid,
	output logic                   access_stall,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output rvmp_pkg::ctrl_cmd_t    cmd
);

	`include "retro_video_memory_port_core_macros.svh"

	localparam logic ST_CLEAR = 1'b0;
	localparam logic ST_RUN   = 1'b1;

	localparam logic [rvmp_pkg::HIRES_ADDR_W-1:0] CLEAR_LAST =
		rvmp_pkg::HIRES_ADDR_W'(rvmp_pkg::HIRES_PAGE_BYTES - 1);

	logic                              state_q;
	logic [rvmp_pkg::HIRES_ADDR_W-1:0] clear_cnt_q;
	logic                              s1_valid_q;
	logic                              out_valid_q;
	logic                              advance;
	logic                              accept;

	assign advance      = s1_valid_q && (!out_valid_q || !result_stall);
	assign access_stall = (state_q != ST_RUN) || (s1_valid_q && !advance);
	assign accept       = access_valid && !access_stall;
	assign result_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.accept     = accept;
		cmd.load_out   = advance;
		cmd.clear_en   = (state_q == ST_CLEAR);
		cmd.clear_addr = clear_cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clear_cnt_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clear_cnt_q <= clear_cnt_q + 1'b1;
			if (clear_cnt_q == CLEAR_LAST) begin
				state_q <= ST_RUN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`RVMP_ASSERT_NEXT(a_accept_fills_s1, accept, s1_valid_q)
	`RVMP_ASSERT_NEXT(a_s1_holds, s1_valid_q && !advance, s1_valid_q)
	`RVMP_ASSERT_NEXT(a_clear_runs, (state_q == ST_CLEAR) && (clear_cnt_q != CLEAR_LAST),
		state_q == ST_CLEAR)
	`RVMP_ASSERT_IMPL(a_out_drops_when_taken, $fell(out_valid_q), !$past(result_stall))

endmodule

`default_nettype wire

// ===== rtl/core/rvmp_datapath.sv =====
`default_nettype none

module rvmp_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rvmp_pkg::access_t   access,
	input  wire rvmp_pkg::ctrl_cmd_t cmd,
	output rvmp_pkg::result_t        result
);

	localparam logic [1:0] REG_NONE = 2'd0;
	localparam logic [1:0] REG_TEXT = 2'd1;
	localparam logic [1:0] REG_HR1  = 2'd2;
	localparam logic [1:0] REG_HR2  = 2'd3;

	logic [6:0] text_mem [rvmp_pkg::CELL_COUNT];
	logic [7:0] hr1_mem  [rvmp_pkg::HIRES_PAGE_BYTES];
	logic [7:0] hr2_mem  [rvmp_pkg::HIRES_PAGE_BYTES];

	// Address decode.
	logic [6:0]                        pos;
	logic [2:0]                        line;
	logic [1:0]                        third;
	logic [6:0]                        third_base;
	logic [5:0]                        col;
	logic [4:0]                        row;
	logic [rvmp_pkg::TEXT_ADDR_W-1:0]  cell_idx;
	logic                              in_text;
	logic                              text_hole;
	logic [1:0]                        region;
	logic [rvmp_pkg::HIRES_ADDR_W-1:0] hr_addr;
	logic                              is_write;
	logic                              is_read;
	logic [7:0]                        sw_code;
	logic [1:0]                        mode_next;
	logic                              page_next;

	logic [1:0] mode_q;
	logic       page_q;

	logic [6:0] rd_text_s1;
	logic [7:0] rd_hr1_s1;
	logic [7:0] rd_hr2_s1;
	logic [1:0] rd_region_s1;
	logic [1:0] mode_s1;
	logic       page_s1;
	rvmp_pkg::result_t out_q;

	assign pos        = access.address[6:0];
	assign line       = access.address[9:7];
	assign text_hole  = (pos >= 7'd120);
	assign third      = (pos >= 7'd80) ? 2'd2 : ((pos >= 7'd40) ? 2'd1 : 2'd0);
	assign third_base = (third == 2'd2) ? 7'd80 : ((third == 2'd1) ? 7'd40 : 7'd0);
	assign col        = 6'(pos - third_base);
	// row = line + 8 * third, and the linear cell is row * 40 + col.
	assign row        = {third, line};
	assign cell_idx   = rvmp_pkg::TEXT_ADDR_W'({row, 5'b0})
	                  + rvmp_pkg::TEXT_ADDR_W'({row, 3'b0})
	                  + rvmp_pkg::TEXT_ADDR_W'(col);
	assign in_text    = (access.address[15:10] == 6'b000001);
	assign hr_addr    = access.address[rvmp_pkg::HIRES_ADDR_W-1:0];

	always_comb begin
		if (in_text && !text_hole) begin
			region = REG_TEXT;
		end else if (access.address[15:13] == 3'b001) begin
			region = REG_HR1;
		end else if (access.address[15:13] == 3'b010) begin
			region = REG_HR2;
		end else begin
			region = REG_NONE;
		end
	end

	assign is_write = cmd.accept && (access.command == rvmp_pkg::CMD_WRITE);
	assign is_read  = (access.command == rvmp_pkg::CMD_READ);
	assign sw_code  = access.address[7:0];

	always_comb begin
		mode_next = mode_q;
		page_next = page_q;
		if (access.command == rvmp_pkg::CMD_SWITCH) begin
			if (sw_code inside {rvmp_pkg::SW_MIXED, rvmp_pkg::SW_HIRES}) begin
				mode_next = rvmp_pkg::MODE_HIRES;
			end
			if (sw_code == rvmp_pkg::SW_PAGE1) begin
				page_next = 1'b0;
			end else if (sw_code == rvmp_pkg::SW_PAGE2) begin
				page_next = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= rvmp_pkg::MODE_TEXT;
			page_q <= 1'b0;
		end else if (cmd.accept) begin
			mode_q <= mode_next;
			page_q <= page_next;
		end
	end

	// The clearing pass after reset shares the write port of each memory.
	always_ff @(posedge clk) begin
		if (cmd.clear_en) begin
			if (cmd.clear_addr < rvmp_pkg::HIRES_ADDR_W'(rvmp_pkg::CELL_COUNT)) begin
				text_mem[cmd.clear_addr[rvmp_pkg::TEXT_ADDR_W-1:0]] <= rvmp_pkg::TEXT_FILL;
			end
		end else if (is_write && (region == REG_TEXT)) begin
			text_mem[cell_idx] <= access.write_data[6:0];
		end
		if (cmd.accept) begin
			rd_text_s1 <= text_mem[cell_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_en) begin
			hr1_mem[cmd.clear_addr] <= 8'h00;
		end else if (is_write && (region == REG_HR1)) begin
			hr1_mem[hr_addr] <= access.write_data;
		end
		if (cmd.accept) begin
			rd_hr1_s1 <= hr1_mem[hr_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_en) begin
			hr2_mem[cmd.clear_addr] <= 8'h00;
		end else if (is_write && (region == REG_HR2)) begin
			hr2_mem[hr_addr] <= access.write_data;
		end
		if (cmd.accept) begin
			rd_hr2_s1 <= hr2_mem[hr_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_region_s1 <= is_read ? region : REG_NONE;
			mode_s1      <= mode_next;
			page_s1      <= page_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			case (rd_region_s1)
				REG_TEXT: out_q.read_data <= {1'b0, rd_text_s1};
				REG_HR1:  out_q.read_data <= rd_hr1_s1;
				REG_HR2:  out_q.read_data <= rd_hr2_s1;
				default:  out_q.read_data <= 8'h00;
			endcase
			out_q.display_mode     <= mode_s1;
			out_q.show_second_page <= page_s1;
		end
	end

	assign result = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/retro_video_memory_port_core.sv =====
// Video memory port: text screen with the interleaved 24-row map, two
// hi-res pages and the mode/page soft switches.
// Input channel access (access_valid, access_stall, access) carries one bus
// access per item: write, read or soft switch. Output channel result
// (result_valid, result_stall, result) returns one item per access with
// the byte read and the display mode and page after that access.
// The memories are read into a registered stage on the accepting edge, and
// the item then moves into the output register, which raises result_valid,
// once that register is empty or its result is being taken. Accesses are
// accepted at one item per cycle while the receiver does not stall.
// After reset a clearing pass fills the text cells with spaces and both
// hi-res pages with zero; access_stall stays high until it ends. When the
// receiver stalls, the result holds and one further item can be accepted
// into the read stage before access_stall rises.
`default_nettype none

module retro_video_memory_port_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              access_valid,
	output logic                   access_stall,
	input  wire rvmp_pkg::access_t access,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output rvmp_pkg::result_t      result
);

	rvmp_pkg::ctrl_cmd_t cmd;

	rvmp_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.access_valid (access_valid),
		.access_stall (access_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd)
	);

	rvmp_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.access (access),
		.cmd    (cmd),
		.result (result)
	);

endmodule

`default_nettype wire
